FILE: src/collision_event_queue_defines.svh
// Assertion macros shared by the collision event queue checker.
// No dependencies; expects clk and rst in scope at the point of use.
`ifndef COLLISION_EVENT_QUEUE_DEFINES_SVH
`define COLLISION_EVENT_QUEUE_DEFINES_SVH

// same-cycle implication
`define CEQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/ceq_pkg.sv
// Shared types and codes for the collision event queue.
// No dependencies.
package ceq_pkg;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_PEEK   = 3'd1,
    OP_REMOVE = 3'd2,
    OP_PURGE  = 3'd3,
    OP_CHECK  = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // control part of the token that walks down the slot chain
  typedef struct packed {
    logic       active;
    logic [2:0] op;
    logic       done;      // insert placed / remove hit
    logic       found;     // peek has a candidate
    logic       conflict;
    logic [8:0] count;
  } tok_ctl_t;

endpackage

FILE: src/ceq_cell.sv
// One slot of the queue: holds an entry and updates the passing token.
// Depends on ceq_pkg.
module ceq_cell #(
  parameter int ID_BITS   = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ceq_pkg::tok_ctl_t    ctl_in,
  input  logic [TIME_BITS-1:0] best_time_in,
  input  logic [15:0]          best_handle_in,
  input  logic [15:0]          q_handle,
  input  logic [ID_BITS-1:0]   q_pa,
  input  logic [ID_BITS-1:0]   q_pb,
  input  logic                 q_two,
  input  logic [TIME_BITS-1:0] q_ot,
  input  logic [TIME_BITS-1:0] q_ta,
  input  logic [TIME_BITS-1:0] q_tb,
  output ceq_pkg::tok_ctl_t    ctl_out,
  output logic [TIME_BITS-1:0] best_time_out,
  output logic [15:0]          best_handle_out
);
  import ceq_pkg::*;

  logic                 valid, valid_next;
  logic [15:0]          handle;
  logic [ID_BITS-1:0]   pa, pb;
  logic                 bflag;
  logic [TIME_BITS-1:0] ot, ta, tb;

  tok_ctl_t             ctl_next;
  logic [TIME_BITS-1:0] best_time_next;
  logic [15:0]          best_handle_next;
  logic                 wr;
  logic                 inv, early;

  always_comb begin
    inv = (pa == q_pa) || (bflag && pb == q_pa) ||
          (q_two && ((pa == q_pb) || (bflag && pb == q_pb)));
    early = ((pa == q_pa) && (ta < q_ta)) || (bflag && (pb == q_pa) && (tb < q_ta)) ||
            (q_two && (((pa == q_pb) && (ta < q_tb)) ||
                       (bflag && (pb == q_pb) && (tb < q_tb))));
  end

  always_comb begin
    ctl_next         = ctl_in;
    best_time_next   = best_time_in;
    best_handle_next = best_handle_in;
    valid_next       = valid;
    wr               = 1'b0;
    if (ctl_in.active) begin
      case (ctl_in.op)
        OP_INSERT: begin
          if (!valid && !ctl_in.done) begin
            wr            = 1'b1;
            valid_next    = 1'b1;
            ctl_next.done = 1'b1;
          end
        end
        OP_PEEK: begin
          if (valid && (!ctl_in.found || ot < best_time_in)) begin
            ctl_next.found   = 1'b1;
            best_time_next   = ot;
            best_handle_next = handle;
          end
        end
        OP_REMOVE: begin
          if (valid && handle == q_handle && !ctl_in.done) begin
            valid_next    = 1'b0;
            ctl_next.done = 1'b1;
          end
        end
        OP_PURGE: begin
          if (valid && inv) begin
            valid_next     = 1'b0;
            ctl_next.count = ctl_in.count + 9'd1;
          end
        end
        OP_CHECK: begin
          if (valid && handle != q_handle && early) ctl_next.conflict = 1'b1;
        end
        OP_CLEAR: begin
          if (valid) begin
            valid_next     = 1'b0;
            ctl_next.count = ctl_in.count + 9'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      ctl_out <= '0;
    end else begin
      valid   <= valid_next;
      ctl_out <= ctl_next;
    end
    best_time_out   <= best_time_next;
    best_handle_out <= best_handle_next;
    if (wr) begin
      handle <= q_handle;
      pa     <= q_pa;
      pb     <= q_two ? q_pb : '0;
      bflag  <= q_two;
      ot     <= q_ot;
      ta     <= q_ta;
      tb     <= q_two ? q_tb : '0;
    end
  end

endmodule

FILE: src/collision_event_queue.sv
// Collision event queue: a chain of ENTRIES slot cells that a token walks,
// one slot per cycle, lowest slot first. Depends on ceq_pkg and ceq_cell.
// An accepted word is registered into the chain start and passes each slot cell in turn,
// then the pending and output registers; s_tready stays low until it leaves pending.
// A new word is taken while the previous result still waits at the output.
// Reset (rst, synchronous): all slots empty, no result pending.
module collision_event_queue #(
  parameter int ENTRIES   = 256,
  parameter int ID_BITS   = 16,
  parameter int TIME_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // handle[15:0], particle_a[31:16], particle_b[47:32], order_time[79:48],
  // time_a[111:80], time_b[143:112]
  input  logic [143:0] s_tdata,
  // operation[2:0], second_present[3]
  input  logic [3:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_handle[15:0], out_time[47:16], conflict[48], removed_count[57:49], zero[63:58]
  output logic [63:0]  m_tdata,
  // status[1:0]
  output logic [1:0]   m_tuser
);
  import ceq_pkg::*;

  logic                 busy;
  logic [15:0]          q_handle;
  logic [ID_BITS-1:0]   q_pa, q_pb;
  logic                 q_two;
  logic [TIME_BITS-1:0] q_ot, q_ta, q_tb;
  tok_ctl_t             start;

  tok_ctl_t             ctl_c [ENTRIES+1];
  logic [TIME_BITS-1:0] bt_c  [ENTRIES+1];
  logic [15:0]          bh_c  [ENTRIES+1];

  logic [31:0] pa_w, pb_w;
  logic [63:0] ot_w, ta_w, tb_w, bt_w;

  logic        pend_valid;
  logic [1:0]  pend_status;
  logic [15:0] pend_handle;
  logic [31:0] pend_time;
  logic        pend_conflict;
  logic [8:0]  pend_count;
  logic [1:0]  fin_status;

  logic [15:0] o_handle;
  logic [31:0] o_time;
  logic        o_conflict;
  logic [8:0]  o_count;

  logic accept, move;

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign move     = pend_valid && (!m_tvalid || m_tready);

  assign pa_w = 32'(s_tdata[31:16]);
  assign pb_w = 32'(s_tdata[47:32]);
  assign ot_w = 64'(s_tdata[79:48]);
  assign ta_w = 64'(s_tdata[111:80]);
  assign tb_w = 64'(s_tdata[143:112]);
  assign bt_w = 64'(bt_c[ENTRIES]);

  assign ctl_c[0] = start;
  assign bt_c[0]  = '0;
  assign bh_c[0]  = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_slot
    ceq_cell #(.ID_BITS(ID_BITS), .TIME_BITS(TIME_BITS)) u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctl_in         (ctl_c[i]),
      .best_time_in   (bt_c[i]),
      .best_handle_in (bh_c[i]),
      .q_handle       (q_handle),
      .q_pa           (q_pa),
      .q_pb           (q_pb),
      .q_two          (q_two),
      .q_ot           (q_ot),
      .q_ta           (q_ta),
      .q_tb           (q_tb),
      .ctl_out        (ctl_c[i+1]),
      .best_time_out  (bt_c[i+1]),
      .best_handle_out(bh_c[i+1])
    );
  end

  always_comb begin
    case (ctl_c[ENTRIES].op)
      OP_INSERT: fin_status = ctl_c[ENTRIES].done  ? ST_OK : ST_FULL;
      OP_PEEK:   fin_status = ctl_c[ENTRIES].found ? ST_OK : ST_EMPTY;
      OP_REMOVE: fin_status = ctl_c[ENTRIES].done  ? ST_OK : ST_NOTFOUND;
      default:   fin_status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      start      <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (accept) begin
        busy  <= 1'b1;
        start <= '{active: 1'b1, op: s_tuser[2:0], default: '0};
      end else begin
        start <= '0;
      end
      if (ctl_c[ENTRIES].active) pend_valid <= 1'b1;
      if (move) begin
        pend_valid <= 1'b0;
        busy       <= 1'b0;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid   <= 1'b0;
      end
    end
    if (accept) begin
      q_handle <= s_tdata[15:0];
      q_pa     <= pa_w[ID_BITS-1:0];
      q_pb     <= pb_w[ID_BITS-1:0];
      q_two    <= s_tuser[3];
      q_ot     <= ot_w[TIME_BITS-1:0];
      q_ta     <= ta_w[TIME_BITS-1:0];
      q_tb     <= tb_w[TIME_BITS-1:0];
    end
    if (ctl_c[ENTRIES].active) begin
      pend_status   <= fin_status;
      pend_conflict <= (ctl_c[ENTRIES].op == OP_CHECK) && ctl_c[ENTRIES].conflict;
      pend_count    <= (ctl_c[ENTRIES].op == OP_PURGE || ctl_c[ENTRIES].op == OP_CLEAR)
                       ? ctl_c[ENTRIES].count : 9'd0;
      if (ctl_c[ENTRIES].op == OP_PEEK && ctl_c[ENTRIES].found) begin
        pend_handle <= bh_c[ENTRIES];
        pend_time   <= bt_w[31:0];
      end else begin
        pend_handle <= '0;
        pend_time   <= '0;
      end
    end
    if (move) begin
      m_tuser    <= pend_status;
      o_handle   <= pend_handle;
      o_time     <= pend_time;
      o_conflict <= pend_conflict;
      o_count    <= pend_count;
    end
  end

  assign m_tdata = {6'd0, o_count, o_conflict, o_time, o_handle};

endmodule

FILE: src/ceq_checker.sv
// Port-level checker for the collision event queue, bound to the top level.
// Depends on collision_event_queue_defines.svh and ceq_pkg.
`include "collision_event_queue_defines.svh"

module ceq_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [63:0]  m_tdata,
  input logic [1:0]   m_tuser
);
  import ceq_pkg::*;

  `CEQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word lost")
  `CEQ_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second word taken")
  `CEQ_ASSERT_NOW(a_full_clean, m_tvalid && m_tuser == ST_FULL, m_tdata == 64'd0, "full with data")
  `CEQ_ASSERT_NOW(a_empty_clean, m_tvalid && m_tuser == ST_EMPTY, m_tdata[47:0] == 48'd0, "empty with data")

endmodule

bind collision_event_queue ceq_checker u_ceq_checker (.*);

FILE: bench/tb_collision_event_queue.sv
// Testbench for collision_event_queue: drives operation words over the stream
// input and checks each result word against a behavioural slot-store model.
// Depends on ceq_pkg and the collision_event_queue RTL.
`timescale 1ns / 100ps

module tb_collision_event_queue;
  import ceq_pkg::*;

  localparam int NSLOT = 256;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] hnd;
    logic [31:0] otime;
    logic        conflict;
    logic [8:0]  count;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [143:0] s_tdata = '0;
  logic [3:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0] m_tuser;

  collision_event_queue u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  // model of the slot store
  logic        mv[NSLOT];
  logic [15:0] mh[NSLOT];
  logic [15:0] mpa[NSLOT];
  logic [15:0] mpb[NSLOT];
  logic        mtwo[NSLOT];
  logic [31:0] mot[NSLOT];
  logic [31:0] mta[NSLOT];
  logic [31:0] mtb[NSLOT];

  result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  bit idle_send = 1'b1;
  bit idle_recv = 1'b1;
  bit drain_done = 1'b0;

  function automatic bit involves(int s, logic [15:0] p);
    return mpa[s] == p || (mtwo[s] && mpb[s] == p);
  endfunction

  function automatic bit earlier(int s, logic [15:0] p, logic [31:0] lim);
    return (mpa[s] == p && mta[s] < lim) || (mtwo[s] && mpb[s] == p && mtb[s] < lim);
  endfunction

  function automatic result_t predict_queue(logic [2:0] op, logic [15:0] h, logic [15:0] pa,
      logic [15:0] pb, logic two, logic [31:0] ot, logic [31:0] ta, logic [31:0] tb);
    result_t r;
    int best;
    r = '0;
    best = -1;
    case (op)
      OP_INSERT: begin
        r.status = ST_FULL;
        for (int s = 0; s < NSLOT; s++)
          if (!mv[s]) begin
            mv[s] = 1'b1; mh[s] = h; mpa[s] = pa; mtwo[s] = two;
            mpb[s] = two ? pb : '0; mot[s] = ot; mta[s] = ta; mtb[s] = two ? tb : '0;
            r.status = ST_OK;
            break;
          end
      end
      OP_PEEK: begin
        for (int s = 0; s < NSLOT; s++)
          if (mv[s] && (best < 0 || mot[s] < mot[best])) best = s;
        if (best < 0) r.status = ST_EMPTY;
        else begin
          r.hnd = mh[best];
          r.otime = mot[best];
        end
      end
      OP_REMOVE: begin
        r.status = ST_NOTFOUND;
        for (int s = 0; s < NSLOT; s++)
          if (mv[s] && mh[s] == h) begin
            mv[s] = 1'b0; r.status = ST_OK;
            break;
          end
      end
      OP_PURGE:
        for (int s = 0; s < NSLOT; s++)
          if (mv[s] && (involves(s, pa) || (two && involves(s, pb)))) begin
            mv[s] = 1'b0; r.count++;
          end
      OP_CHECK:
        for (int s = 0; s < NSLOT; s++)
          if (mv[s] && mh[s] != h && (earlier(s, pa, ta) || (two && earlier(s, pb, tb)))) begin
            r.conflict = 1'b1;
            break;
          end
      OP_CLEAR:
        for (int s = 0; s < NSLOT; s++)
          if (mv[s]) begin
            mv[s] = 1'b0; r.count++;
          end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(logic [2:0] op, logic [15:0] h, logic [15:0] pa, logic [15:0] pb,
      logic two, logic [31:0] ot, logic [31:0] ta, logic [31:0] tb);
    while (idle_send && $urandom_range(99) < 24) @(posedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {tb, ta, ot, pb, pa, h};
    s_tuser <= {two, op};
    do @(posedge clk); while (!s_tready);
    pending_results = {pending_results, predict_queue(op, h, pa, pb, two, ot, ta, tb)};
    s_tvalid <= 1'b0;
    // idle gap so valid is never driven twice in one step
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // small id pool so purges and checks hit
  function automatic logic [15:0] rand_id();
    return ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(15));
  endfunction

  task automatic rand_op(int ins_weight);
    logic [2:0] op;
    int k;
    k = $urandom_range(99);
    if (k < ins_weight) op = OP_INSERT;
    else if (k < 97) op = 3'($urandom_range(1, 5));
    else op = 3'($urandom_range(6, 7));
    send_word(op, ($urandom_range(1) ? 16'($urandom_range(31)) : 16'($urandom)),
              rand_id(), rand_id(), 1'($urandom),
              ($urandom_range(3) == 0 ? $urandom : 32'($urandom_range(300))),
              ($urandom_range(3) == 0 ? $urandom : 32'($urandom_range(300))),
              ($urandom_range(3) == 0 ? $urandom : 32'($urandom_range(300))));
  endtask

  task automatic test_directed();
    send_word(OP_PEEK, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0, 32'h0, 32'h0);
    send_word(OP_REMOVE, 16'h1234, 16'h0, 16'h0, 1'b0, 32'h0, 32'h0, 32'h0);
    send_word(OP_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF,
              32'hFFFFFFFF);
    send_word(OP_INSERT, 16'h0000, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h0, 32'h5);
    send_word(OP_INSERT, 16'h0007, 16'h0003, 16'h0004, 1'b1, 32'h0, 32'h10, 32'h20);
    send_word(OP_INSERT, 16'h0007, 16'h0005, 16'h0000, 1'b0, 32'h8, 32'h10, 32'h20);
    // tie: lowest slot
    send_word(OP_PEEK, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0, 32'h0, 32'h0);
    // own handle skipped
    send_word(OP_CHECK, 16'h0007, 16'h0003, 16'h0000, 1'b0, 32'h0, 32'h11, 32'h0);
    send_word(OP_CHECK, 16'h0001, 16'h0003, 16'h0004, 1'b1, 32'h0, 32'h10, 32'h21);
    // one-body b
    send_word(OP_CHECK, 16'h0001, 16'h0000, 16'h0000, 1'b1, 32'h0, 32'h1, 32'h6);
    // b ignored when absent
    send_word(OP_PURGE, 16'h0, 16'h0000, 16'h0004, 1'b0, 32'h0, 32'h0, 32'h0);
    // duplicate: lowest
    send_word(OP_REMOVE, 16'h0007, 16'h0, 16'h0, 1'b0, 32'h0, 32'h0, 32'h0);
    send_word(OP_PEEK, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0, 32'h0, 32'h0);
    send_word(3'd6, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF,
              32'hFFFFFFFF);
    send_word(3'd7, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0, 32'h0, 32'h0);
    send_word(OP_PURGE, 16'h0, 16'hFFFF, 16'h0005, 1'b1, 32'h0, 32'h0, 32'h0);
    send_word(OP_CLEAR, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0, 32'h0, 32'h0);
    send_word(OP_CLEAR, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0, 32'h0, 32'h0);
  endtask

  task automatic test_full_store();
    for (int i = 0; i < NSLOT + 2; i++)
      send_word(OP_INSERT, 16'(i), 16'(i % 16), 16'($urandom), 1'($urandom), $urandom,
                $urandom, $urandom);
    send_word(OP_PEEK, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0, 32'h0, 32'h0);
    // removes a full store
    send_word(OP_CLEAR, 16'h0, 16'h0, 16'h0, 1'b0, 32'h0, 32'h0, 32'h0);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      idle_send = !(i >= 300 && i < 450);
      idle_recv = idle_send;
      rand_op(i % 400 < 200 ? 60 : 30);
      if (i == 700) wait_drained();
    end
    idle_send = 1'b1;
    idle_recv = 1'b1;
  endtask

  // result checker
  always @(posedge clk) begin
    result_t got, exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata[15:0], m_tdata[47:16], m_tdata[48], m_tdata[57:49]};
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
        end
        if (got.hnd !== exp_r.hnd) begin
          $error("out_handle exp %h got %h", exp_r.hnd, got.hnd); errors++;
        end
        if (got.otime !== exp_r.otime) begin
          $error("out_time exp %h got %h", exp_r.otime, got.otime); errors++;
        end
        if (got.conflict !== exp_r.conflict) begin
          $error("conflict exp %0d got %0d", exp_r.conflict, got.conflict); errors++;
        end
        if (got.count !== exp_r.count) begin
          $error("removed_count exp %0d got %0d", exp_r.count, got.count); errors++;
        end
      end
    end
    m_tready <= rst ? 1'b0 : (!idle_recv || $urandom_range(99) >= 24);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 4000000 && !drain_done) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < NSLOT; s++) mv[s] = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_store();
    test_random(1150);
    wait_drained();
    repeat (300) @(posedge clk);
    drain_done = 1'b1;
    if (errors == 0 && pending_results.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
